// ===== hw/rtl/conv3_pkg.sv =====
// Shared constants, types and helpers of the 3x3 RGB convolution block.
package conv3_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COEF_FRAC_BITS = 11;
  localparam int LINE_DEPTH     = 2 * MAX_WIDTH + 4;

  localparam int PIX_BITS        = 8;
  localparam int RGB_BITS        = 3 * PIX_BITS;
  localparam int COEF_BITS       = 16;
  localparam int CFG_WIDTH_BITS  = 12;
  localparam int CFG_HEIGHT_BITS = 13;
  localparam int CFG_DATA_BITS   = 48;
  localparam int CFG_INDEX_BITS  = 3;

  localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS    = $clog2(MAX_HEIGHT + 1);
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
  localparam int PEND_BITS = $clog2(LINE_DEPTH + 1);

  localparam int PROD_BITS   = COEF_BITS + PIX_BITS + 1;
  localparam int ROWSUM_BITS = PROD_BITS + 2;
  localparam int SUM_BITS    = PROD_BITS + 4;

  // power of two, so the pointers wrap on their own
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET         = 12'd640;
  localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET        = 13'd480;
  localparam logic [CFG_DATA_BITS-1:0]   KERNEL_TOP_RESET    = 48'd0;
  localparam logic [CFG_DATA_BITS-1:0]   KERNEL_MIDDLE_RESET = 48'd2048;
  localparam logic [CFG_DATA_BITS-1:0]   KERNEL_BOTTOM_RESET = 48'd0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MIDDLE = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_index_e;

  typedef logic [1:0] bank_t;
  localparam bank_t BANK_FIRST = 2'd0;
  localparam bank_t BANK_LAST  = 2'd2;

  typedef struct packed {
    logic [W_BITS-1:0]                   width;
    logic [H_BITS-1:0]                   height;
    logic [2:0][CFG_DATA_BITS-1:0]       kernel;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    bank_t               bank;
    logic                top_ok;
    logic                bot_ok;
    logic                left_ok;
    logic                right_ok;
    logic                last;
    logic [2:0]          fwd_a;
    logic [2:0]          fwd_b;
    logic [RGB_BITS-1:0] wdata;
  } issue_t;

  typedef struct packed {
    logic                last;
    logic [PIX_BITS-1:0] blue;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] red;
  } result_t;

  function automatic bank_t bank_next(input bank_t b);
    return (b == BANK_LAST) ? BANK_FIRST : bank_t'(b + 2'd1);
  endfunction

  function automatic bank_t bank_prev(input bank_t b);
    return (b == BANK_FIRST) ? BANK_LAST : bank_t'(b - 2'd1);
  endfunction

endpackage

// ===== hw/rtl/convolution_3x3_rgb.sv =====
// Top level of the streaming 3x3 RGB convolution block.
//
// Pixels enter in raster order on the s_axis channel; tuser marks a drain
// transaction that carries no pixel and only pushes out one pending result.
// Filtered pixels leave on the m_axis channel, tlast on the last pixel of
// a frame. Output (r,c) is formed once input (r+1,c+1) has arrived, clipped
// at the frame edges, so within a frame results trail inputs by W+1
// transactions; drains flush the final row.
// Three row banks of MAX_WIDTH entries each hold the line store; each has
// one write port and two read ports, so every transaction reads a full new
// window column in the same cycle it writes its pixel.
// Throughput: one transaction per cycle while s_axis_tready is high; a result
// passes the issue, product and row-sum registers and the result queue to m_axis.
// The configuration port writes a register on any cycle with cfg_we_i high;
// write only while the block is idle.
// Reset clears counters, pending count and the result queue; the line store
// is not cleared and needs no clearing pass.
// When the receiver stalls, results queue in an 8-entry buffer; tready falls
// once 8 results are queued or in flight, and rises as they are taken.
module convolution_3x3_rgb (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [23:0]                            s_axis_tdata,  // red_in, green_in, blue_in
  input  logic                                   s_axis_tuser,  // drain
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [23:0]                            m_axis_tdata,  // red_out, green_out, blue_out
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_we_i,
  input  logic [conv3_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [conv3_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i
);

  conv3_pkg::cfg_t                          cfg;
  conv3_pkg::issue_t                        issue;
  conv3_pkg::result_t                       res;
  conv3_pkg::result_t                       out_data;
  logic                                     res_valid;
  logic                                     room;
  logic                                     reserve;
  logic [2:0]                               ram_we;
  logic [conv3_pkg::COL_BITS-1:0]           ram_waddr;
  logic [conv3_pkg::RGB_BITS-1:0]           ram_wdata;
  logic [conv3_pkg::COL_BITS-1:0]           ram_raddr_a;
  logic [conv3_pkg::COL_BITS-1:0]           ram_raddr_b;
  logic [2:0][conv3_pkg::RGB_BITS-1:0]      rdata_a;
  logic [2:0][conv3_pkg::RGB_BITS-1:0]      rdata_b;

  conv3_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  conv3_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_valid_i     (s_axis_tvalid),
    .s_data_i      (s_axis_tdata),
    .s_drain_i     (s_axis_tuser),
    .room_i        (room),
    .s_ready_o     (s_axis_tready),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b),
    .reserve_o     (reserve),
    .issue_o       (issue)
  );

  for (genvar b = 0; b < 3; b++) begin : g_bank
    conv3_line_ram u_ram (
      .clk_i     (clk_i),
      .we_i      (ram_we[b]),
      .waddr_i   (ram_waddr),
      .wdata_i   (ram_wdata),
      .raddr_a_i (ram_raddr_a),
      .raddr_b_i (ram_raddr_b),
      .rdata_a_o (rdata_a[b]),
      .rdata_b_o (rdata_b[b])
    );
  end

  conv3_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .issue_i     (issue),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  conv3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reserve_i   (reserve),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_ready_i (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_data),
    .room_o      (room)
  );

  assign m_axis_tdata = {out_data.blue, out_data.green, out_data.red};
  assign m_axis_tlast = out_data.last;

endmodule

// ===== hw/rtl/conv3_cfg.sv =====
// Configuration registers with frame geometry saturation.
module conv3_cfg (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [conv3_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [conv3_pkg::CFG_DATA_BITS-1:0]     cfg_wdata_i,
  output conv3_pkg::cfg_t                         cfg_o
);

  logic [conv3_pkg::W_BITS-1:0]                 width_q;
  logic [conv3_pkg::H_BITS-1:0]                 height_q;
  logic [2:0][conv3_pkg::CFG_DATA_BITS-1:0]     kernel_q;

  function automatic logic [conv3_pkg::W_BITS-1:0] sat_width(
    input logic [conv3_pkg::CFG_WIDTH_BITS-1:0] v
  );
    logic [conv3_pkg::W_BITS-1:0] r;
    if (v == '0) begin
      r = conv3_pkg::W_BITS'(1);
    end else if (int'(v) > conv3_pkg::MAX_WIDTH) begin
      r = conv3_pkg::W_BITS'(conv3_pkg::MAX_WIDTH);
    end else begin
      r = conv3_pkg::W_BITS'(v);
    end
    return r;
  endfunction

  function automatic logic [conv3_pkg::H_BITS-1:0] sat_height(
    input logic [conv3_pkg::CFG_HEIGHT_BITS-1:0] v
  );
    logic [conv3_pkg::H_BITS-1:0] r;
    if (v == '0) begin
      r = conv3_pkg::H_BITS'(1);
    end else if (int'(v) > conv3_pkg::MAX_HEIGHT) begin
      r = conv3_pkg::H_BITS'(conv3_pkg::MAX_HEIGHT);
    end else begin
      r = conv3_pkg::H_BITS'(v);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= sat_width(conv3_pkg::WIDTH_RESET);
      height_q    <= sat_height(conv3_pkg::HEIGHT_RESET);
      kernel_q[0] <= conv3_pkg::KERNEL_TOP_RESET;
      kernel_q[1] <= conv3_pkg::KERNEL_MIDDLE_RESET;
      kernel_q[2] <= conv3_pkg::KERNEL_BOTTOM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        conv3_pkg::CFG_IMAGE_WIDTH: begin
          width_q <= sat_width(cfg_wdata_i[conv3_pkg::CFG_WIDTH_BITS-1:0]);
        end
        conv3_pkg::CFG_IMAGE_HEIGHT: begin
          height_q <= sat_height(cfg_wdata_i[conv3_pkg::CFG_HEIGHT_BITS-1:0]);
        end
        conv3_pkg::CFG_KERNEL_TOP:    kernel_q[0] <= cfg_wdata_i;
        conv3_pkg::CFG_KERNEL_MIDDLE: kernel_q[1] <= cfg_wdata_i;
        conv3_pkg::CFG_KERNEL_BOTTOM: kernel_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;
  assign cfg_o.kernel = kernel_q;

endmodule

// ===== hw/rtl/conv3_line_ram.sv =====
// One row bank of the line store: one write port, two registered read ports.
module conv3_line_ram (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [conv3_pkg::COL_BITS-1:0]      waddr_i,
  input  logic [conv3_pkg::RGB_BITS-1:0]      wdata_i,
  input  logic [conv3_pkg::COL_BITS-1:0]      raddr_a_i,
  input  logic [conv3_pkg::COL_BITS-1:0]      raddr_b_i,
  output logic [conv3_pkg::RGB_BITS-1:0]      rdata_a_o,
  output logic [conv3_pkg::RGB_BITS-1:0]      rdata_b_o
);

  logic [conv3_pkg::RGB_BITS-1:0] mem_q [conv3_pkg::MAX_WIDTH];
  logic [conv3_pkg::RGB_BITS-1:0] rd_a_q;
  logic [conv3_pkg::RGB_BITS-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

// ===== hw/rtl/conv3_ctrl.sv =====
// Input and output position counters, pending count, line store addressing.
module conv3_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  conv3_pkg::cfg_t                     cfg_i,
  input  logic                                s_valid_i,
  input  logic [conv3_pkg::RGB_BITS-1:0]      s_data_i,
  input  logic                                s_drain_i,
  input  logic                                room_i,
  output logic                                s_ready_o,
  output logic [2:0]                          ram_we_o,
  output logic [conv3_pkg::COL_BITS-1:0]      ram_waddr_o,
  output logic [conv3_pkg::RGB_BITS-1:0]      ram_wdata_o,
  output logic [conv3_pkg::COL_BITS-1:0]      ram_raddr_a_o,
  output logic [conv3_pkg::COL_BITS-1:0]      ram_raddr_b_o,
  output logic                                reserve_o,
  output conv3_pkg::issue_t                   issue_o
);

  logic [conv3_pkg::COL_BITS-1:0]  in_col_q, in_col_d;
  conv3_pkg::bank_t                in_bank_q, in_bank_d;
  logic [conv3_pkg::COL_BITS-1:0]  out_col_q, out_col_d;
  logic [conv3_pkg::ROW_BITS-1:0]  out_row_q, out_row_d;
  conv3_pkg::bank_t                out_bank_q, out_bank_d;
  logic [conv3_pkg::PEND_BITS-1:0] pending_q, pending_d;
  conv3_pkg::issue_t               issue_q, issue_d;

  logic                            accept;
  logic                            pix;
  logic [conv3_pkg::RGB_BITS-1:0]  pixel;
  logic [conv3_pkg::W_BITS-1:0]    in_col_inc;
  logic [conv3_pkg::W_BITS-1:0]    col_inc;
  logic [conv3_pkg::H_BITS-1:0]    row_inc;
  logic [conv3_pkg::COL_BITS-1:0]  col_next;
  logic                            right_ok;
  logic                            bot_ok;
  logic [conv3_pkg::PEND_BITS-1:0] need;
  logic [conv3_pkg::PEND_BITS-1:0] pend_inc;
  logic                            emit;

  assign s_ready_o = room_i;
  assign accept    = s_valid_i && room_i;
  assign pix       = accept && !s_drain_i;
  assign pixel     = {s_data_i[conv3_pkg::PIX_BITS-1:0],
                      s_data_i[conv3_pkg::PIX_BITS +: conv3_pkg::PIX_BITS],
                      s_data_i[2*conv3_pkg::PIX_BITS +: conv3_pkg::PIX_BITS]};

  assign in_col_inc = conv3_pkg::W_BITS'(in_col_q) + conv3_pkg::W_BITS'(1);
  assign col_inc    = conv3_pkg::W_BITS'(out_col_q) + conv3_pkg::W_BITS'(1);
  assign row_inc    = conv3_pkg::H_BITS'(out_row_q) + conv3_pkg::H_BITS'(1);
  assign col_next   = conv3_pkg::COL_BITS'(col_inc);
  assign right_ok   = col_inc < cfg_i.width;
  assign bot_ok     = row_inc < cfg_i.height;

  assign need = (bot_ok ? conv3_pkg::PEND_BITS'(cfg_i.width) : '0)
              + conv3_pkg::PEND_BITS'(right_ok);
  assign pend_inc = pending_q + conv3_pkg::PEND_BITS'(
                      pix && (pending_q < conv3_pkg::PEND_BITS'(conv3_pkg::LINE_DEPTH)));
  assign emit = accept && (pend_inc > need);

  always_comb begin
    pending_d  = pend_inc - conv3_pkg::PEND_BITS'(emit);
    in_col_d   = in_col_q;
    in_bank_d  = in_bank_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_bank_d = out_bank_q;

    if (pix) begin
      if (in_col_inc < cfg_i.width) begin
        in_col_d = conv3_pkg::COL_BITS'(in_col_inc);
      end else begin
        in_col_d  = '0;
        in_bank_d = conv3_pkg::bank_next(in_bank_q);
      end
    end

    if (emit) begin
      if (right_ok) begin
        out_col_d = col_next;
      end else begin
        out_col_d  = '0;
        out_row_d  = bot_ok ? conv3_pkg::ROW_BITS'(row_inc) : '0;
        out_bank_d = conv3_pkg::bank_next(out_bank_q);
      end
    end

    issue_d.valid    = emit;
    issue_d.bank     = out_bank_q;
    issue_d.top_ok   = out_row_q != '0;
    issue_d.bot_ok   = bot_ok;
    issue_d.left_ok  = out_col_q != '0;
    issue_d.right_ok = right_ok;
    issue_d.last     = !bot_ok && !right_ok;
    issue_d.wdata    = pixel;
    for (int b = 0; b < 3; b++) begin
      issue_d.fwd_a[b] = pix && (in_bank_q == conv3_pkg::bank_t'(b)) && (in_col_q == out_col_q);
      issue_d.fwd_b[b] = pix && (in_bank_q == conv3_pkg::bank_t'(b)) && (in_col_q == col_next);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_bank_q  <= conv3_pkg::BANK_FIRST;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_bank_q <= conv3_pkg::BANK_FIRST;
      pending_q  <= '0;
      issue_q    <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_bank_q  <= in_bank_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_bank_q <= out_bank_d;
      pending_q  <= pending_d;
      issue_q    <= issue_d;
    end
  end

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      ram_we_o[b] = pix && (in_bank_q == conv3_pkg::bank_t'(b));
    end
  end

  assign ram_waddr_o   = in_col_q;
  assign ram_wdata_o   = pixel;
  assign ram_raddr_a_o = out_col_q;
  assign ram_raddr_b_o = col_next;
  assign reserve_o     = emit;
  assign issue_o       = issue_q;

endmodule

// ===== hw/rtl/conv3_mac.sv =====
// Window assembly, 27 products, row sums and per-channel clamp.
module conv3_mac (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  conv3_pkg::cfg_t                          cfg_i,
  input  conv3_pkg::issue_t                        issue_i,
  input  logic [2:0][conv3_pkg::RGB_BITS-1:0]      rdata_a_i,
  input  logic [2:0][conv3_pkg::RGB_BITS-1:0]      rdata_b_i,
  output logic                                     res_valid_o,
  output conv3_pkg::result_t                       res_o
);

  logic [2:0][conv3_pkg::RGB_BITS-1:0]       col_a;
  logic [2:0][conv3_pkg::RGB_BITS-1:0]       col_b;
  conv3_pkg::bank_t                          row_bank [3];
  logic [2:0]                                row_ok;
  logic [2:0][conv3_pkg::RGB_BITS-1:0]       center;
  logic [2:0][2:0][conv3_pkg::RGB_BITS-1:0]  tap;
  logic [2:0][conv3_pkg::RGB_BITS-1:0]       left_q;

  logic signed [conv3_pkg::PROD_BITS-1:0]    prod_d   [3][3][3];
  logic signed [conv3_pkg::PROD_BITS-1:0]    prod_q   [3][3][3];
  logic signed [conv3_pkg::ROWSUM_BITS-1:0]  rowsum_d [3][3];
  logic signed [conv3_pkg::ROWSUM_BITS-1:0]  rowsum_q [3][3];
  logic signed [conv3_pkg::SUM_BITS-1:0]     sum      [3];
  logic                                      v1_q, v2_q;
  logic                                      last1_q, last2_q;

  function automatic logic [conv3_pkg::PIX_BITS-1:0] clamp_sum(
    input logic signed [conv3_pkg::SUM_BITS-1:0] s
  );
    logic [conv3_pkg::PIX_BITS-1:0] r;
    if (s[conv3_pkg::SUM_BITS-1]) begin
      r = '0;
    end else if (|s[conv3_pkg::SUM_BITS-2:conv3_pkg::COEF_FRAC_BITS+conv3_pkg::PIX_BITS]) begin
      r = '1;
    end else begin
      r = s[conv3_pkg::COEF_FRAC_BITS +: conv3_pkg::PIX_BITS];
    end
    return r;
  endfunction

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      col_a[b] = issue_i.fwd_a[b] ? issue_i.wdata : rdata_a_i[b];
      col_b[b] = issue_i.fwd_b[b] ? issue_i.wdata : rdata_b_i[b];
    end
    row_bank[0] = conv3_pkg::bank_prev(issue_i.bank);
    row_bank[1] = issue_i.bank;
    row_bank[2] = conv3_pkg::bank_next(issue_i.bank);
    row_ok = {issue_i.bot_ok, 1'b1, issue_i.top_ok};
    for (int i = 0; i < 3; i++) begin
      center[i] = col_a[row_bank[i]];
      tap[i][0] = (row_ok[i] && issue_i.left_ok) ? left_q[i] : '0;
      tap[i][1] = row_ok[i] ? center[i] : '0;
      tap[i][2] = (row_ok[i] && issue_i.right_ok) ? col_b[row_bank[i]] : '0;
    end
  end

  // channel 0 blue, 1 green, 2 red
  always_comb begin
    logic signed [conv3_pkg::COEF_BITS-1:0] coef;
    logic signed [conv3_pkg::PIX_BITS:0]    px;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          coef = cfg_i.kernel[i][j*conv3_pkg::COEF_BITS +: conv3_pkg::COEF_BITS];
          px   = {1'b0, tap[i][j][k*conv3_pkg::PIX_BITS +: conv3_pkg::PIX_BITS]};
          prod_d[k][i][j] = coef * px;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        rowsum_d[k][i] = conv3_pkg::ROWSUM_BITS'(prod_q[k][i][0])
                       + conv3_pkg::ROWSUM_BITS'(prod_q[k][i][1])
                       + conv3_pkg::ROWSUM_BITS'(prod_q[k][i][2]);
      end
      sum[k] = conv3_pkg::SUM_BITS'(rowsum_q[k][0])
             + conv3_pkg::SUM_BITS'(rowsum_q[k][1])
             + conv3_pkg::SUM_BITS'(rowsum_q[k][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    rowsum_q <= rowsum_d;
    last1_q  <= issue_i.last;
    last2_q  <= last1_q;
    if (issue_i.valid) begin
      left_q <= center;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue_i.valid;
      v2_q <= v1_q;
    end
  end

  assign res_valid_o = v2_q;
  assign res_o.last  = last2_q;
  assign res_o.blue  = clamp_sum(sum[0]);
  assign res_o.green = clamp_sum(sum[1]);
  assign res_o.red   = clamp_sum(sum[2]);

endmodule

// ===== hw/rtl/conv3_out_fifo.sv =====
// Result queue with credit count that throttles the input side.
module conv3_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  reserve_i,
  input  logic                  push_i,
  input  conv3_pkg::result_t    push_data_i,
  input  logic                  pop_ready_i,
  output logic                  valid_o,
  output conv3_pkg::result_t    data_o,
  output logic                  room_o
);

  conv3_pkg::result_t                   mem_q [conv3_pkg::FIFO_DEPTH];
  logic [conv3_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [conv3_pkg::FIFO_CNT_BITS-1:0]  count_q, count_d;
  logic [conv3_pkg::FIFO_CNT_BITS-1:0]  credit_q, credit_d;
  logic                                 pop;

  assign valid_o  = count_q != '0;
  assign data_o   = mem_q[rd_ptr_q];
  assign pop      = valid_o && pop_ready_i;
  assign room_o   = credit_q < conv3_pkg::FIFO_CNT_BITS'(conv3_pkg::FIFO_DEPTH);
  assign count_d  = count_q + conv3_pkg::FIFO_CNT_BITS'(push_i)
                  - conv3_pkg::FIFO_CNT_BITS'(pop);
  assign credit_d = credit_q + conv3_pkg::FIFO_CNT_BITS'(reserve_i)
                  - conv3_pkg::FIFO_CNT_BITS'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      credit_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + conv3_pkg::FIFO_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + conv3_pkg::FIFO_PTR_BITS'(1);
      end
      count_q  <= count_d;
      credit_q <= credit_d;
    end
  end

endmodule

// ===== hw/rtl/conv3_checker.sv =====
// Port-level checks of the convolution block and their binding.
module conv3_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   s_axis_tvalid,
  input logic                                   s_axis_tready,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready,
  input logic [23:0]                            m_axis_tdata,
  input logic                                   m_axis_tlast
);

  logic        in_acc;
  logic        out_acc;
  logic [31:0] items_q, items_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign items_d = items_q + 32'(in_acc) - 32'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      items_q <= '0;
    end else begin
      items_q <= items_d;
    end
  end

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> items_q != 32'd0)
    else $error("more results than accepted transactions");

  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result shown during reset");

endmodule

bind convolution_3x3_rgb conv3_checker u_checker (.*);
